// ===== sv/pcbw_pkg.sv =====
// Shared constants, command codes and types of the page column byte pixel writer.
`default_nettype none

package pcbw_pkg;

  // Frame memory geometry.
  localparam int FRAME_WIDTH  = 160;
  localparam int PAGE_COLUMNS = 128;
  localparam int COL_OFFSET   = 16;
  localparam int LINE_OFFSET  = 8;
  localparam int ADDR_W       = 14;

  // Command codes carried in the kind field.
  typedef enum logic [2:0] {
    KIND_SELECT_PAGE = 3'd0,
    KIND_SEQ_WRITE   = 3'd1,
    KIND_ADD_BITS    = 3'd2,
    KIND_SET_BYTE    = 3'd3,
    KIND_CLEAR_BYTE  = 3'd4
  } kind_t;

  // One decoded column byte: where it goes, what it paints and which rows are written.
  typedef struct packed {
    logic [6:0] column;
    logic [2:0] page;
    logic [7:0] pattern;
    logic [7:0] color;
    logic [7:0] mask;
  } job_t;

  // Emitter status seen by the top level.
  typedef struct packed {
    logic       in_ready;
    logic [7:0] pending;
  } emit_status_t;

endpackage

`default_nettype wire

// ===== sv/pcbw_cmd_if.sv =====
// Command channel: one column byte command per request.
`default_nettype none

interface pcbw_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] column;
  logic [2:0] page;
  logic [7:0] pattern;
  logic [7:0] color;

  modport source (output valid, kind, column, page, pattern, color, input ready);
  modport sink   (input valid, kind, column, page, pattern, color, output ready);
endinterface

`default_nettype wire

// ===== sv/pcbw_pix_if.sv =====
// Pixel channel: one frame memory byte write per request.
`default_nettype none

interface pcbw_pix_if;
  logic        valid;
  logic        ready;
  logic [13:0] pixel_address;
  logic [7:0]  pixel_value;
  logic        last_write;

  modport source (output valid, pixel_address, pixel_value, last_write, input ready);
  modport sink   (input valid, pixel_address, pixel_value, last_write, output ready);
endinterface

`default_nettype wire

// ===== sv/pcbw_decode.sv =====
// Command decoder with the sequential write cursor and the draw color register.
`default_nettype none

module pcbw_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [2:0]    kind,
  input  wire logic [6:0]    column,
  input  wire logic [2:0]    page,
  input  wire logic [7:0]    pattern,
  input  wire logic [7:0]    color,
  input  wire logic          cfg_wen,
  input  wire logic [7:0]    cfg_wdata,
  output pcbw_pkg::job_t     job
);

  logic [2:0] current_page;
  logic [6:0] current_column;
  logic [7:0] draw_color;
  logic [7:0] column_inc;

  assign column_inc = {1'b0, current_column} + 8'd1;

  // Translate the command into a job for the emitter.
  always_comb begin
    job.column  = column;
    job.page    = page;
    job.pattern = pattern;
    job.color   = color;
    job.mask    = 8'h00;
    unique case (pcbw_pkg::kind_t'(kind))
      pcbw_pkg::KIND_SEQ_WRITE: begin
        job.column = current_column;
        job.page   = current_page;
        job.color  = draw_color;
        job.mask   = 8'hFF;
      end
      pcbw_pkg::KIND_ADD_BITS: begin
        job.mask = pattern;
      end
      pcbw_pkg::KIND_SET_BYTE: begin
        job.mask = 8'hFF;
      end
      pcbw_pkg::KIND_CLEAR_BYTE: begin
        job.pattern = 8'h00;
        job.color   = 8'h00;
        job.mask    = 8'hFF;
      end
      default: begin
        job.mask = 8'h00;
      end
    endcase
  end

  // Cursor update and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_page   <= 3'd0;
      current_column <= 7'd0;
      draw_color     <= 8'hFF;
    end else begin
      if (cfg_wen) begin
        draw_color <= cfg_wdata;
      end
      if (accept) begin
        if (pcbw_pkg::kind_t'(kind) == pcbw_pkg::KIND_SELECT_PAGE) begin
          current_page   <= page;
          current_column <= 7'd0;
        end else if (pcbw_pkg::kind_t'(kind) == pcbw_pkg::KIND_SEQ_WRITE) begin
          if (column_inc >= 8'(pcbw_pkg::PAGE_COLUMNS)) begin
            current_column <= 7'd0;
            current_page   <= current_page + 3'd1;
          end else begin
            current_column <= column_inc[6:0];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcbw_emit.sv =====
// Job register, row walker and pixel output register.
`default_nettype none

module pcbw_emit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire pcbw_pkg::job_t      job,
  output pcbw_pkg::emit_status_t   status,
  pcbw_pix_if.source               pix
);

  pcbw_pkg::job_t job_q;
  logic [7:0]     mask;
  logic [7:0]     mask_next;
  logic           issue;
  logic [2:0]     row_sel;
  logic [6:0]     line;
  logic [13:0]    address;

  // Lowest row still to be written.
  always_comb begin
    logic found;
    found   = 1'b0;
    row_sel = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mask[i] && !found) begin
        row_sel = 3'(i);
        found   = 1'b1;
      end
    end
  end

  // One pixel per cycle whenever the output register is free or draining.
  assign issue     = (mask != 8'h00) && (!pix.valid || pix.ready);
  assign mask_next = issue ? (mask & (mask - 8'd1)) : mask;

  assign status.in_ready = (mask_next == 8'h00);
  assign status.pending  = mask;

  // Frame address of the selected row.
  assign line    = {1'b0, job_q.page, 3'b000} + 7'(pcbw_pkg::LINE_OFFSET) + {4'd0, row_sel};
  assign address = 14'(job_q.column) + 14'(pcbw_pkg::COL_OFFSET)
                 + 14'(17'(line) * 17'(pcbw_pkg::FRAME_WIDTH));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= 8'h00;
      pix.valid <= 1'b0;
    end else begin
      if (accept) begin
        mask <= job.mask;
      end else begin
        mask <= mask_next;
      end
      if (!pix.valid || pix.ready) begin
        pix.valid <= issue;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      job_q <= job;
    end
    if (issue) begin
      pix.pixel_address <= address;
      pix.pixel_value   <= job_q.pattern[row_sel] ? job_q.color : 8'h00;
      pix.last_write    <= (mask_next == 8'h00);
    end
  end

endmodule

`default_nettype wire

// ===== sv/page_column_byte_to_pixel_writer_core.sv =====
// Top level of the page column byte to pixel writer.
//
// Commands arrive on the cmd channel, one column byte per request, and each
// becomes up to eight frame memory byte writes on the pix channel, rows in
// order from top to bottom, the final one flagged by last_write.
// Each row of an accepted command is registered into the pix output
// register. The row walker issues one pixel per cycle unless the receiver
// stalls, writing eight rows for sequential, set and clear writes, the
// number of set bits for add, and none for select page and unused kinds.
// The next command is taken in the cycle that issues the last row of the
// current one, so commands stream with no gap. When the receiver stalls, the
// held pixel stays in the output register, the walker pauses and cmd.ready
// stays low until the last row can issue. The user writes the draw color
// register through cfg_wen/cfg_wdata only while idle; the block does not
// enforce it. Synchronous reset empties the walker and output register,
// sets the cursor to page 0, column 0, and the draw color to white (255).
`default_nettype none

module page_column_byte_to_pixel_writer_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wen,
  input  wire logic [7:0] cfg_wdata,
  pcbw_cmd_if.sink        cmd,
  pcbw_pix_if.source      pix
);

  pcbw_pkg::job_t         job;
  pcbw_pkg::emit_status_t status;
  logic                   accept;

  assign cmd.ready = status.in_ready;
  assign accept    = cmd.valid && cmd.ready;

  // Command decode and cursor.
  pcbw_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (cmd.kind),
    .column    (cmd.column),
    .page      (cmd.page),
    .pattern   (cmd.pattern),
    .color     (cmd.color),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .job       (job)
  );

  // Pixel emission.
  pcbw_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .job    (job),
    .status (status),
    .pix    (pix)
  );

`ifndef SYNTHESIS
  // A new command is only taken when at most the final row is left.
  a_ready_only_near_end: assert property (@(posedge clk) disable iff (rst)
    status.in_ready |-> ($countones(status.pending) <= 1))
    else $error("command accepted with rows outstanding");

  // A clear command loads all eight rows.
  a_clear_loads_all: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == pcbw_pkg::KIND_CLEAR_BYTE) |=> (status.pending == 8'hFF))
    else $error("clear command did not load eight rows");

  // Select page produces no pixel writes.
  a_select_no_rows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == pcbw_pkg::KIND_SELECT_PAGE) |=> (status.pending == 8'h00))
    else $error("select page produced pixel rows");
`endif

endmodule

`default_nettype wire

// ===== sim/page_column_byte_to_pixel_writer_core_test.sv =====
// Self-checking testbench for the page column byte to pixel writer core.
`default_nettype none

module page_column_byte_to_pixel_writer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_PERIOD   = 5;
  localparam int RESET_CYCLES      = 11;
  localparam int SETTLE_CYCLES     = 6;
  localparam int CYCLE_LIMIT       = 300000;
  localparam int ROWS_PER_BYTE     = 8;
  localparam int PAGE_COUNT        = 8;
  localparam int FIRST_UNUSED_KIND = pcbw_pkg::KIND_CLEAR_BYTE + 1;
  localparam int LAST_UNUSED_KIND  = 7;
  localparam logic [7:0] WHITE     = 8'hFF;
  localparam logic [7:0] BLACK     = 8'h00;

  // One column byte command as it goes onto the cmd channel.
  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] column;
    logic [2:0] page;
    logic [7:0] pattern;
    logic [7:0] color;
  } column_cmd_t;

  // One frame memory byte write as it should come out of the pix channel.
  typedef struct packed {
    logic [pcbw_pkg::ADDR_W-1:0] address;
    logic [7:0]                  value;
    logic                        last;
  } pixel_write_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wen;
  logic [7:0] cfg_wdata;

  pcbw_cmd_if cmd_bus ();
  pcbw_pix_if pix_bus ();

  page_column_byte_to_pixel_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .pix       (pix_bus)
  );

  // Shadow state of the display emulation.
  logic [7:0]   shadow_draw_color;
  logic [2:0]   cursor_page;
  logic [6:0]   cursor_column;
  pixel_write_t pending_pixels[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;

  always #(CLK_HALF_PERIOD) clk = ~clk;

  // Run limit; a run that gets here has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_column_byte_to_pixel_writer_core test failed");
      $finish;
    end
  end

  // Receiver: ready drops at random according to the current idle rate.
  always @(posedge clk) begin
    pix_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Frame memory address of one row of a column byte, wrapped to the address width.
  function automatic logic [pcbw_pkg::ADDR_W-1:0] pixel_address_of(input logic [6:0] column,
                                                                  input logic [2:0] page,
                                                                  input int row);
    int unsigned addr;
    addr = column + pcbw_pkg::COL_OFFSET
         + (page * ROWS_PER_BYTE + pcbw_pkg::LINE_OFFSET + row) * pcbw_pkg::FRAME_WIDTH;
    return addr[pcbw_pkg::ADDR_W-1:0];
  endfunction

  // Queue the pixel writes of one column byte; all_rows paints clear bits black.
  function automatic void queue_column_byte(input logic [6:0] column, input logic [2:0] page,
                                            input logic [7:0] pattern, input logic [7:0] color,
                                            input bit all_rows);
    int first_index;
    pixel_write_t px;
    first_index = pending_pixels.size();
    for (int row = 0; row < ROWS_PER_BYTE; row++) begin
      if (pattern[row] || all_rows) begin
        px.address = pixel_address_of(column, page, row);
        px.value   = pattern[row] ? color : BLACK;
        px.last    = 1'b0;
        pending_pixels.push_back(px);
      end
    end
    if (pending_pixels.size() > first_index)
      pending_pixels[pending_pixels.size() - 1].last = 1'b1;
  endfunction

  // Work out the pixel writes that one accepted command causes and move the cursor.
  function automatic void predict_pixel_writes(input column_cmd_t c);
    case (c.kind)
      pcbw_pkg::KIND_SELECT_PAGE: begin
        cursor_page   = c.page;
        cursor_column = '0;
      end
      pcbw_pkg::KIND_SEQ_WRITE: begin
        queue_column_byte(cursor_column, cursor_page, c.pattern, shadow_draw_color, 1'b1);
        if (int'(cursor_column) + 1 >= pcbw_pkg::PAGE_COLUMNS) begin
          cursor_column = '0;
          cursor_page   = cursor_page + 3'd1;
        end else begin
          cursor_column = cursor_column + 7'd1;
        end
      end
      pcbw_pkg::KIND_ADD_BITS:
        queue_column_byte(c.column, c.page, c.pattern, c.color, 1'b0);
      pcbw_pkg::KIND_SET_BYTE:
        queue_column_byte(c.column, c.page, c.pattern, c.color, 1'b1);
      pcbw_pkg::KIND_CLEAR_BYTE:
        queue_column_byte(c.column, c.page, BLACK, BLACK, 1'b1);
      default: ;
    endcase
  endfunction

  // Compare every accepted pixel write with the oldest outstanding one.
  always @(posedge clk) begin
    pixel_write_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel write, address %0d value %0d last %0b", $time,
                 pix_bus.pixel_address, pix_bus.pixel_value, pix_bus.last_write);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_bus.pixel_address !== want.address) begin
          $display("%0t: pixel_address expected %0d, actual %0d", $time, want.address,
                   pix_bus.pixel_address);
          error_count++;
        end
        if (pix_bus.pixel_value !== want.value) begin
          $display("%0t: pixel_value expected %0d, actual %0d", $time, want.value,
                   pix_bus.pixel_value);
          error_count++;
        end
        if (pix_bus.last_write !== want.last) begin
          $display("%0t: last_write expected %0b, actual %0b", $time, want.last,
                   pix_bus.last_write);
          error_count++;
        end
      end
    end
  end

  function automatic column_cmd_t make_cmd(input logic [2:0] kind, input logic [6:0] column,
                                           input logic [2:0] page, input logic [7:0] pattern,
                                           input logic [7:0] color);
    column_cmd_t c;
    c.kind    = kind;
    c.column  = column;
    c.page    = page;
    c.pattern = pattern;
    c.color   = color;
    return c;
  endfunction

  // Send one command request, with random idle cycles ahead of it.
  task automatic send_command(input column_cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid   <= 1'b1;
    cmd_bus.kind    <= c.kind;
    cmd_bus.column  <= c.column;
    cmd_bus.page    <= c.page;
    cmd_bus.pattern <= c.pattern;
    cmd_bus.color   <= c.color;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    predict_pixel_writes(c);
  endtask

  // Hold off new requests until every outstanding pixel write has come out.
  task automatic wait_for_all_pixels();
    cmd_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the draw color register while the block is idle.
  task automatic write_draw_color(input logic [7:0] color);
    wait_for_all_pixels();
    cfg_wen   <= 1'b1;
    cfg_wdata <= color;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    shadow_draw_color = color;
  endtask

  task automatic set_idle_rates(input int unsigned sender_pct, input int unsigned receiver_pct);
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
  endtask

  // Directed commands: field extremes, every command kind and the unused kinds.
  task automatic test_directed_commands();
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, 8'hA5, 8'h00));
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, WHITE, 8'h00));
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, BLACK, WHITE));
    write_draw_color(BLACK);
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd127, 3'd7, WHITE, WHITE));
    write_draw_color(8'h5A);
    send_command(make_cmd(pcbw_pkg::KIND_SELECT_PAGE, 7'd127, 3'd7, WHITE, WHITE));
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, 8'h3C, 8'h00));
    send_command(make_cmd(pcbw_pkg::KIND_SELECT_PAGE, 7'd0, 3'd0, BLACK, BLACK));
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, 8'h81, 8'h00));
    send_command(make_cmd(pcbw_pkg::KIND_ADD_BITS, 7'd64, 3'd4, BLACK, WHITE));
    send_command(make_cmd(pcbw_pkg::KIND_ADD_BITS, 7'd0, 3'd0, WHITE, BLACK));
    send_command(make_cmd(pcbw_pkg::KIND_ADD_BITS, 7'd127, 3'd7, 8'h80, WHITE));
    send_command(make_cmd(pcbw_pkg::KIND_ADD_BITS, 7'd1, 3'd2, 8'h01, 8'h77));
    send_command(make_cmd(pcbw_pkg::KIND_SET_BYTE, 7'd0, 3'd0, 8'h5A, WHITE));
    send_command(make_cmd(pcbw_pkg::KIND_SET_BYTE, 7'd127, 3'd7, WHITE, BLACK));
    send_command(make_cmd(pcbw_pkg::KIND_SET_BYTE, 7'd42, 3'd5, BLACK, 8'hC3));
    send_command(make_cmd(pcbw_pkg::KIND_CLEAR_BYTE, 7'd127, 3'd7, WHITE, WHITE));
    send_command(make_cmd(pcbw_pkg::KIND_CLEAR_BYTE, 7'd0, 3'd0, BLACK, BLACK));
    for (int k = FIRST_UNUSED_KIND; k <= LAST_UNUSED_KIND; k++)
      send_command(make_cmd(3'(k), 7'($urandom_range(127)), 3'($urandom_range(7)),
                            8'($urandom_range(255)), 8'($urandom_range(255))));
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, 8'h0F, 8'h00));
    write_draw_color(WHITE);
    send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'd0, 3'd0, 8'hF0, 8'h00));
  endtask

  // A random command; the mix favors the drawing kinds and leans on edge patterns.
  function automatic column_cmd_t random_command();
    column_cmd_t c;
    int unsigned pick;
    pick      = $urandom_range(99);
    c.column  = 7'($urandom_range(127));
    c.page    = 3'($urandom_range(7));
    c.color   = 8'($urandom_range(255));
    case ($urandom_range(4))
      0:       c.pattern = BLACK;
      1:       c.pattern = WHITE;
      default: c.pattern = 8'($urandom_range(255));
    endcase
    if (pick < 5)       c.kind = 3'($urandom_range(LAST_UNUSED_KIND, FIRST_UNUSED_KIND));
    else if (pick < 15) c.kind = pcbw_pkg::KIND_SELECT_PAGE;
    else if (pick < 45) c.kind = pcbw_pkg::KIND_SEQ_WRITE;
    else if (pick < 65) c.kind = pcbw_pkg::KIND_ADD_BITS;
    else if (pick < 85) c.kind = pcbw_pkg::KIND_SET_BYTE;
    else                c.kind = pcbw_pkg::KIND_CLEAR_BYTE;
    return c;
  endfunction

  // Random command stream; halfway through the sender waits for the pixels to drain.
  task automatic test_random_commands(input int count);
    column_cmd_t c;
    int sent;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < count) begin
      c = random_command();
      send_command(c);
      if (c.kind <= pcbw_pkg::KIND_CLEAR_BYTE) sent++;
      if (!drained && sent >= count / 2) begin
        wait_for_all_pixels();
        drained = 1'b1;
      end
    end
  endtask

  // Sequential writes across the end of the last page so the cursor wraps to page 0.
  task automatic test_cursor_wrap();
    send_command(make_cmd(pcbw_pkg::KIND_SELECT_PAGE, 7'($urandom_range(127)),
                          3'(PAGE_COUNT - 1), 8'($urandom_range(255)),
                          8'($urandom_range(255))));
    for (int i = 0; i < pcbw_pkg::PAGE_COLUMNS + 2; i++)
      send_command(make_cmd(pcbw_pkg::KIND_SEQ_WRITE, 7'($urandom_range(127)),
                            3'($urandom_range(7)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wen           = 1'b0;
    cfg_wdata         = '0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.kind      = pcbw_pkg::KIND_SELECT_PAGE;
    cmd_bus.column    = '0;
    cmd_bus.page      = '0;
    cmd_bus.pattern   = '0;
    cmd_bus.color     = '0;
    pix_bus.ready     = 1'b0;
    shadow_draw_color = WHITE;
    cursor_page       = '0;
    cursor_column     = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle_rates(9, 81);
    test_directed_commands();
    test_random_commands(40);
    write_draw_color(8'($urandom_range(255)));
    test_cursor_wrap();

    set_idle_rates(81, 9);
    write_draw_color(8'($urandom_range(255)));
    test_random_commands(40);

    set_idle_rates(0, 0);
    write_draw_color(BLACK);
    test_random_commands(40);

    wait_for_all_pixels();
    if (error_count == 0) begin
      $display("page_column_byte_to_pixel_writer_core test passed");
    end else begin
      $display("page_column_byte_to_pixel_writer_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
